[hw/rtl/dss_pkg.sv]
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the delimiter stream splitter
// Window size, result kinds, register indexes and the front-to-back command.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int DELIM_MAX  = 8;
	localparam int LEN_LIM    = (DELIM_MAX < 8) ? DELIM_MAX : 8;
	localparam int CNT_W      = $clog2(DELIM_MAX + 1);
	localparam int FLUSH_N    = (DELIM_MAX > 1) ? DELIM_MAX - 1 : 1;
	localparam int FL_W       = $clog2(FLUSH_N + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int IDX_W      = 4;
	localparam int CFG_W      = 64;

	localparam logic [CFG_W-1:0] DELIM_BYTES_RST = CFG_W'(44);
	localparam logic [3:0]       DELIM_LEN_RST   = 4'd1;

	typedef enum logic [IDX_W-1:0] {
		REG_DELIM_BYTES = 4'd0,
		REG_DELIM_LEN   = 4'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_BYTE = 2'd1,
		RES_END  = 2'd2
	} res_kind_t;

	typedef struct packed {
		res_kind_t                  first_kind;
		logic [7:0]                 first_byte;
		logic [FLUSH_N-1:0][7:0]    flush_bytes;
		logic [FL_W-1:0]            flush_cnt;
		logic                       eos;
	} cmd_t;

endpackage

[hw/rtl/dss_front.sv]
// ----------------------------------------------------------------------------
// dss_front: window and match stage
// Holds the lookahead window, compares it to the delimiter and issues one
// command per beat that gives results or ends the string.
// ----------------------------------------------------------------------------
module dss_front
	import dss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             s_tuser,
	input  logic             s_tlast,
	input  logic             cfg_valid,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             q_full,
	output logic             push,
	output cmd_t             push_cmd
);

	logic [CFG_W-1:0]            delim_bytes_q;
	logic [3:0]                  delim_len_q;
	logic [DELIM_MAX-1:0][7:0]   win_q;
	logic [CNT_W-1:0]            cnt_q;

	logic [CNT_W-1:0]            len_eff;
	logic [CNT_W-1:0]            cnt0;
	logic [CNT_W-1:0]            cnt_a;
	logic [CNT_W-1:0]            cnt_b;
	logic [DELIM_MAX-1:0][7:0]   win_a;
	logic [DELIM_MAX-1:0][7:0]   win_b;
	logic                        full;
	logic                        match;
	logic                        accept;
	logic                        cfg_hit;
	res_kind_t                   kind;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign cfg_hit  = cfg_valid && (cfg_index == REG_DELIM_BYTES || cfg_index == REG_DELIM_LEN);

	always_comb begin
		if (delim_len_q == 4'd0) begin
			len_eff = CNT_W'(1);
		end else if (32'(delim_len_q) > LEN_LIM) begin
			len_eff = CNT_W'(LEN_LIM);
		end else begin
			len_eff = CNT_W'(delim_len_q);
		end
	end

	always_comb begin
		cnt0 = (cnt_q >= len_eff) ? '0 : cnt_q;
		win_a = win_q;
		for (int i = 0; i < DELIM_MAX; i++) begin
			if (s_tuser && CNT_W'(i) == cnt0) begin
				win_a[i] = s_tdata;
			end
		end
		cnt_a = cnt0 + CNT_W'(s_tuser);
		full  = s_tuser && (cnt_a == len_eff);
		match = 1'b1;
		for (int i = 0; i < DELIM_MAX; i++) begin
			if (CNT_W'(i) < len_eff && win_a[i] != delim_bytes_q[8*i +: 8]) begin
				match = 1'b0;
			end
		end
		win_b = win_a;
		cnt_b = cnt_a;
		kind  = RES_NONE;
		if (full && match) begin
			kind  = RES_END;
			cnt_b = '0;
		end else if (full) begin
			kind = RES_BYTE;
			for (int i = 0; i < DELIM_MAX - 1; i++) begin
				win_b[i] = win_a[i+1];
			end
			cnt_b = cnt_a - CNT_W'(1);
		end
	end

	always_comb begin
		push_cmd.first_kind = kind;
		push_cmd.first_byte = win_a[0];
		for (int i = 0; i < FLUSH_N; i++) begin
			push_cmd.flush_bytes[i] = win_b[i];
		end
		push_cmd.flush_cnt = s_tlast ? cnt_b[FL_W-1:0] : '0;
		push_cmd.eos       = s_tlast;
		push = accept && (kind != RES_NONE || s_tlast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes_q <= DELIM_BYTES_RST;
			delim_len_q   <= DELIM_LEN_RST;
			cnt_q         <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DELIM_BYTES) begin
				delim_bytes_q <= cfg_data;
			end
			if (cfg_index == REG_DELIM_LEN) begin
				delim_len_q <= cfg_data[3:0];
			end
			if (cfg_hit) begin
				cnt_q <= '0;
			end
		end else if (accept) begin
			cnt_q <= s_tlast ? '0 : cnt_b;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= win_b;
		end
	end

endmodule

[hw/rtl/dss_fifo.sv]
// ----------------------------------------------------------------------------
// dss_fifo: command queue
// Short register queue between the match stage and the result sequencer.
// ----------------------------------------------------------------------------
module dss_fifo
	import dss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic full,
	output logic empty
);

	cmd_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[hw/rtl/dss_back.sv]
// ----------------------------------------------------------------------------
// dss_back: result sequencer
// Turns each command into its result beats, one beat per cycle while m_tready
// allows it, through an output register.
// ----------------------------------------------------------------------------
module dss_back
	import dss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_cmd,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic       m_tlast
);

	logic                    first_pend_q;
	res_kind_t               first_kind_q;
	logic [7:0]              first_byte_q;
	logic [FLUSH_N-1:0][7:0] fl_q;
	logic [FL_W-1:0]         fl_left_q;
	logic                    end_pend_q;

	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic [1:0]              out_user_q;
	logic                    out_last_q;

	logic                    cur_valid;
	logic                    emit;
	logic                    done_after;
	logic                    load;
	logic [7:0]              nx_byte;
	logic                    nx_bv;
	logic                    nx_pe;
	logic                    nx_last;

	assign cur_valid = first_pend_q || (fl_left_q != '0) || end_pend_q;
	assign emit      = cur_valid && (!out_valid_q || m_tready);

	always_comb begin
		if (first_pend_q) begin
			done_after = (fl_left_q == '0) && !end_pend_q;
		end else if (fl_left_q != '0) begin
			done_after = (fl_left_q == FL_W'(1)) && !end_pend_q;
		end else begin
			done_after = 1'b1;
		end
	end

	assign load = (!cur_valid || (emit && done_after)) && !q_empty;
	assign pop  = load;

	always_comb begin
		if (first_pend_q) begin
			nx_bv   = (first_kind_q == RES_BYTE);
			nx_pe   = (first_kind_q == RES_END);
			nx_byte = nx_bv ? first_byte_q : 8'd0;
			nx_last = 1'b0;
		end else if (fl_left_q != '0) begin
			nx_bv   = 1'b1;
			nx_pe   = 1'b0;
			nx_byte = fl_q[0];
			nx_last = 1'b0;
		end else begin
			nx_bv   = 1'b0;
			nx_pe   = 1'b1;
			nx_byte = 8'd0;
			nx_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pend_q <= 1'b0;
			fl_left_q    <= '0;
			end_pend_q   <= 1'b0;
		end else if (load) begin
			first_pend_q <= (q_cmd.first_kind != RES_NONE);
			fl_left_q    <= q_cmd.flush_cnt;
			end_pend_q   <= q_cmd.eos;
		end else if (emit) begin
			if (first_pend_q) begin
				first_pend_q <= 1'b0;
			end else if (fl_left_q != '0) begin
				fl_left_q <= fl_left_q - FL_W'(1);
			end else begin
				end_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_kind_q <= q_cmd.first_kind;
			first_byte_q <= q_cmd.first_byte;
			fl_q         <= q_cmd.flush_bytes;
		end else if (emit && !first_pend_q && fl_left_q != '0) begin
			for (int i = 0; i < FLUSH_N - 1; i++) begin
				fl_q[i] <= fl_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= nx_byte;
			out_user_q <= {nx_pe, nx_bv};
			out_last_q <= nx_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

[hw/rtl/delimiter_stream_splitter.sv]
// ----------------------------------------------------------------------------
// delimiter_stream_splitter: split a byte stream at a multibyte delimiter
// Front stage matches the window, a command queue decouples it from the
// sequencer that writes out part bytes and part ends.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata data_byte, tuser has_byte, tlast end_of_string
// m_*       out  m_tvalid/m_tready  tdata out_byte, tuser byte_valid|part_end, tlast last
// cfg_*     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// one input beat per cycle while s_tready is high; the sequencer sends one
// result beat per cycle while m_tready is high; end-of-string flushes the window
// reset: window empty, delimiter a comma of length 1
// a 4-entry command queue absorbs flushes; s_tready drops only when it fills
// a delimiter register write empties the window; cfg_ready is always high
// ----------------------------------------------------------------------------
module delimiter_stream_splitter
	import dss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // data_byte
	input  logic             s_tuser,   // has_byte
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic [1:0]       m_tuser,   // byte_valid, part_end
	output logic             m_tlast,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	assign cfg_ready = 1'b1;

	dss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	dss_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	dss_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_cmd    (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[dv/delimiter_stream_splitter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimiter_stream_splitter_tb: self-checking bench for the stream splitter
// Feeds directed and random strings under several delimiter settings, predicts
// the part bytes and part ends of every input beat and compares each output
// beat in order, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module delimiter_stream_splitter_tb;
	import dss_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 16;
	localparam int HOLD_CYCLES   = 150;
	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_ITEMS  = 160;
	localparam int BURST_ITEMS   = 20;
	localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 4'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       part_end;
		logic       last;
	} part_beat_t;

	typedef struct {
		bit               is_cfg;
		bit               drain;
		logic [7:0]       data;
		logic             has;
		logic             eos;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] val;
	} stim_op_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic [1:0]       m_tuser;
	logic             m_tlast;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	delimiter_stream_splitter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// splitter state as predicted
	logic [7:0]       win [DELIM_MAX];
	int unsigned      win_cnt = 0;
	logic [CFG_W-1:0] delim_q = DELIM_BYTES_RST;
	logic [3:0]       delim_len_q = DELIM_LEN_RST;

	part_beat_t expected_beats[$];
	stim_op_t   stim_q[$];

	int  errors = 0;
	int  in_beats = 0;
	int  idle_cycles = 0;
	int  n_items = 0;
	bit  in_acc = 0;
	bit  cfg_acc = 0;
	bit  tx_busy = 0;
	bit  cfg_busy = 0;
	int  tx_gap = 0;
	int  settle = 0;
	int  rx_stall = 0;
	int  rx_hold_left = 0;
	bit  rx_held = 0;

	// generator view of the delimiter
	logic [7:0]       gen_alpha [3];
	logic [CFG_W-1:0] gen_delim = DELIM_BYTES_RST;
	int unsigned      gen_len = 1;

	function automatic int unsigned clamp_len(logic [3:0] v);
		int unsigned n;
		n = v;
		if (n < 1) n = 1;
		if (n > LEN_LIM) n = LEN_LIM;
		return n;
	endfunction

	function automatic int pick_gap();
		int r;
		if (rx_hold_left > 0 || (in_beats >= 100 && in_beats < 140)) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_beat(logic [7:0] b, logic bv, logic pe, logic ls);
		part_beat_t p;
		p.out_byte   = b;
		p.byte_valid = bv;
		p.part_end   = pe;
		p.last       = ls;
		expected_beats.insert(expected_beats.size(), p);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		if (idx == REG_DELIM_BYTES) delim_q = val;
		else if (idx == REG_DELIM_LEN) delim_len_q = val[3:0];
		else return;
		win_cnt = 0;
	endtask

	task automatic split_item(logic [7:0] b, logic has, logic eos);
		int unsigned len;
		bit hit;
		len = clamp_len(delim_len_q);
		if (win_cnt >= len) win_cnt = 0;
		if (has) begin
			win[win_cnt] = b;
			win_cnt++;
			if (win_cnt == len) begin
				hit = 1;
				for (int i = 0; i < len; i++)
					if (win[i] != delim_q[8*i +: 8]) hit = 0;
				if (hit) begin
					win_cnt = 0;
					push_beat(8'h00, 1'b0, 1'b1, 1'b0);
				end else begin
					push_beat(win[0], 1'b1, 1'b0, 1'b0);
					for (int i = 1; i < win_cnt; i++) win[i-1] = win[i];
					win_cnt--;
				end
			end
		end
		if (eos) begin
			for (int i = 0; i < win_cnt; i++) push_beat(win[i], 1'b1, 1'b0, 1'b0);
			win_cnt = 0;
			push_beat(8'h00, 1'b0, 1'b1, 1'b1);
		end
	endtask

	task automatic add_item(logic [7:0] d, logic h, logic e, bit drn);
		stim_op_t op;
		op = '{is_cfg: 0, drain: drn, data: d, has: h, eos: e, idx: '0, val: '0};
		stim_q.insert(stim_q.size(), op);
		if (h || e) n_items++;
	endtask

	task automatic add_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		stim_op_t op;
		op = '{is_cfg: 1, drain: 0, data: '0, has: 0, eos: 0, idx: idx, val: val};
		stim_q.insert(stim_q.size(), op);
		if (idx == REG_DELIM_BYTES) gen_delim = val;
		else if (idx == REG_DELIM_LEN) gen_len = clamp_len(val[3:0]);
	endtask

	// well-formed pieces: whole delimiters, delimiter prefixes, alphabet chars, noise
	task automatic add_string(int pieces, bit close, bit drn);
		logic [7:0] bytes[$];
		int r;
		int k;
		bit eos_on_byte;
		for (int p = 0; p < pieces; p++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				for (int i = 0; i < gen_len; i++)
					bytes.insert(bytes.size(), gen_delim[8*i +: 8]);
			end else if (r < 50) begin
				k = $urandom_range(1, gen_len);
				for (int i = 0; i < k; i++) bytes.insert(bytes.size(), gen_delim[8*i +: 8]);
			end else if (r < 88) begin
				bytes.insert(bytes.size(), gen_alpha[$urandom_range(0, 2)]);
			end else begin
				bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
			end
		end
		eos_on_byte = close && bytes.size() > 0 && $urandom_range(0, 1);
		foreach (bytes[i])
			add_item(bytes[i], 1'b1, eos_on_byte && i == bytes.size() - 1, drn && i == 0);
		if (close && !eos_on_byte)
			add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drn && bytes.size() == 0);
	endtask

	// sender and config driver
	always @(negedge clk) begin
		logic tx_v_next;
		logic cfg_v_next;
		stim_op_t op;
		if (arst_n) begin
			tx_v_next  = s_tvalid;
			cfg_v_next = cfg_valid;
			if (in_acc) begin
				in_acc    = 0;
				tx_busy   = 0;
				tx_v_next = 1'b0;
				tx_gap    = pick_gap();
			end
			if (cfg_acc) begin
				cfg_acc    = 0;
				cfg_busy   = 0;
				cfg_v_next = 1'b0;
			end
			if (tx_busy || cfg_busy || expected_beats.size() != 0) settle = 0;
			else settle++;
			if (!tx_busy && !cfg_busy) begin
				if (rx_hold_left > 0) tx_gap = 0;
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (stim_q.size() > 0) begin
					op = stim_q[0];
					if (op.is_cfg) begin
						if (settle >= SETTLE_CYCLES) begin
							void'(stim_q.pop_front());
							cfg_busy   = 1;
							cfg_v_next = 1'b1;
							cfg_index <= op.idx;
							cfg_data  <= op.val;
						end
					end else if (!op.drain || expected_beats.size() == 0) begin
						void'(stim_q.pop_front());
						tx_busy   = 1;
						tx_v_next = 1'b1;
						s_tdata  <= op.data;
						s_tuser  <= op.has;
						s_tlast  <= op.eos;
					end
				end
			end
			s_tvalid  <= tx_v_next;
			cfg_valid <= cfg_v_next;
		end
	end

	// receiver with random stalls and one long hold
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (!rx_held && in_beats >= 4) begin
				rx_held      = 1;
				rx_hold_left = HOLD_CYCLES;
				m_tready    <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_stall = pick_gap();
			end
		end
	end

	// monitor: prediction on input beats, in-order check on output beats
	always @(posedge clk) begin
		part_beat_t got;
		part_beat_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				write_reg(cfg_index, cfg_data);
				cfg_acc = 1;
			end
			if (s_tvalid && s_tready) begin
				split_item(s_tdata, s_tuser, s_tlast);
				in_acc = 1;
				in_beats++;
			end
			if (m_tvalid && m_tready) begin
				got.out_byte   = m_tdata;
				got.byte_valid = m_tuser[0];
				got.part_end   = m_tuser[1];
				got.last       = m_tlast;
				if (expected_beats.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t unexpected beat: byte %h bv %b pe %b last %b", $realtime,
							got.out_byte, got.byte_valid, got.part_end, got.last);
				end else begin
					want = expected_beats.pop_front();
					if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
						got.part_end !== want.part_end || got.last !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("%0t mismatch: exp byte %h bv %b pe %b last %b, got byte %h bv %b pe %b last %b",
								$realtime, want.out_byte, want.byte_valid, want.part_end, want.last,
								got.out_byte, got.byte_valid, got.part_end, got.last);
					end
				end
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] dv;
		logic [3:0] lv;
		int target;
		int phase_end;
		int phase;

		gen_alpha[0] = 8'h61;
		gen_alpha[1] = 8'h62;
		gen_alpha[2] = 8'h2C;

		// reset delimiter: comma, length 1
		add_item(8'h78, 1'b1, 1'b0, 0);
		add_item(8'h2C, 1'b1, 1'b0, 0);
		add_item(8'h79, 1'b1, 1'b1, 0);
		add_item(8'h2C, 1'b1, 1'b1, 0);     // trailing delimiter
		add_item(8'hA5, 1'b0, 1'b1, 0);     // empty string
		add_item(8'h5A, 1'b0, 1'b0, 0);     // no byte, no end
		add_item(8'h00, 1'b1, 1'b0, 0);
		add_item(8'hFF, 1'b1, 1'b1, 0);

		// burst of one result per beat while the receiver holds off
		for (int i = 0; i < BURST_ITEMS; i++)
			add_item(gen_alpha[i % 3], 1'b1, (i == BURST_ITEMS - 1), 0);

		// full window mismatch then flush: most beats per item
		add_cfg(REG_DELIM_BYTES, 64'h0807060504030201);
		add_cfg(REG_DELIM_LEN, 64'd8);
		for (int i = 1; i <= 7; i++) add_item(8'(i), 1'b1, 1'b0, 0);
		add_item(8'h09, 1'b1, 1'b1, 0);

		// length zero acts as one
		add_cfg(REG_DELIM_BYTES, 64'd0);
		add_cfg(REG_DELIM_LEN, 64'd0);
		add_item(8'h00, 1'b1, 1'b0, 0);
		add_item(8'h5A, 1'b1, 1'b1, 0);

		// oversized length saturates
		add_cfg(REG_DELIM_BYTES, {CFG_W{1'b1}});
		add_cfg(REG_DELIM_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(8'hFF, 1'b1, 1'b0, 0);
		add_item(8'hFF, 1'b1, 1'b1, 0);

		// spare register index keeps the window, a real write drops it
		add_cfg(REG_DELIM_BYTES, 64'h0000_0000_0063_6261);
		add_cfg(REG_DELIM_LEN, 64'd3);
		add_item(8'h61, 1'b1, 1'b0, 0);
		add_item(8'h62, 1'b1, 1'b0, 0);
		add_cfg(REG_SPARE_FIRST, 64'h0123_4567_89AB_CDEF);
		add_item(8'h63, 1'b1, 1'b1, 0);
		add_item(8'h61, 1'b1, 1'b0, 0);
		add_item(8'h62, 1'b1, 1'b0, 0);
		add_cfg(REG_DELIM_LEN, 64'd3);
		add_item(8'h63, 1'b1, 1'b1, 0);

		target = n_items + RANDOM_ITEMS;
		phase = 0;
		while (n_items < target) begin
			for (int i = 0; i < 3; i++) gen_alpha[i] = 8'($urandom_range(0, 255));
			for (int i = 0; i < 8; i++)
				dv[8*i +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
					: gen_alpha[$urandom_range(0, 2)];
			if ($urandom_range(0, 6) == 0) lv = ($urandom_range(0, 1)) ? 4'd0
				: 4'($urandom_range(9, 15));
			else lv = 4'($urandom_range(1, 8));
			if ($urandom_range(0, 3) == 0)
				add_cfg(4'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
					{$urandom, $urandom});
			if ($urandom_range(0, 1)) begin
				add_cfg(REG_DELIM_BYTES, dv);
				add_cfg(REG_DELIM_LEN, {$urandom, 28'($urandom), lv});
			end else begin
				add_cfg(REG_DELIM_LEN, {$urandom, 28'($urandom), lv});
				add_cfg(REG_DELIM_BYTES, dv);
			end
			phase_end = n_items + 28;
			while (n_items < phase_end) begin
				if ($urandom_range(0, 19) == 0)
					add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 0);
				add_string($urandom_range(0, 6), 1, phase == 0 || $urandom_range(0, 9) == 0);
				phase++;
			end
			if ($urandom_range(0, 2) == 0) add_string($urandom_range(1, 3), 0, 0);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stim_q.size() != 0 || tx_busy || cfg_busy) @(posedge clk);
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_beats.size() != 0) errors++;
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
